// ===== src/smt_pkg.sv =====
// Shared types and constants for the sliding median of timestamps core.
// No dependencies.
package smt_pkg;

    localparam int TIME_W = 32;
    localparam int USED_W = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_cmd;

endpackage

// ===== src/smt_window_mem.sv =====
// Window store: one write port, one read port, registered read data.
// Uses smt_pkg for the command struct.
module smt_window_mem #(
    parameter int DEPTH = 11,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  logic              i_clk,
    input  smt_pkg::t_mem_cmd i_cmd,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DW-1:0]     i_wr_data,
    output logic [DW-1:0]     o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/smt_rank_engine.sv =====
// Rank-update sequencer: each stored entry keeps its value and its sorted rank.
// One pass per item re-ranks the held entries and picks the one at rank k/2.
// Uses smt_pkg; drives smt_window_mem through the top level.
module smt_rank_engine #(
    parameter int WINDOW = 11,
    parameter int IW     = 4,
    parameter int RW     = 4,
    parameter int CW     = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [smt_pkg::TIME_W-1:0]  i_block_time,
    output smt_pkg::t_mem_cmd           o_mem_cmd,
    output logic [IW-1:0]               o_rd_addr,
    output logic [IW-1:0]               o_wr_addr,
    output logic [smt_pkg::TIME_W+RW-1:0] o_wr_data,
    input  logic [smt_pkg::TIME_W+RW-1:0] i_rd_data,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [smt_pkg::TIME_W-1:0]  o_median,
    output logic [CW-1:0]               o_used
);

    smt_pkg::t_state r_state, n_state;

    logic [smt_pkg::TIME_W-1:0] r_t, n_t;
    logic [smt_pkg::TIME_W-1:0] r_med, n_med;
    logic [IW-1:0]              r_s, n_s;
    logic [IW-1:0]              r_slot, n_slot;
    logic [IW-1:0]              r_pa, n_pa;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_held, n_held;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic [CW-1:0]              r_used, n_used;
    logic [RW-1:0]              r_k2, n_k2;
    logic [RW-1:0]              r_rold, n_rold;
    logic [RW-1:0]              r_le, n_le;
    logic                       r_full, n_full;
    logic                       r_pv, n_pv;

    logic [smt_pkg::TIME_W-1:0] rd_val;
    logic [RW-1:0]              rd_rank;
    logic [RW-1:0]              rank_a;
    logic [RW-1:0]              rank_b;
    logic [CW-1:0]              cnt_new;
    logic                       is_full;
    logic                       issue;
    logic                       scan_end;

    assign rd_val  = i_rd_data[smt_pkg::TIME_W+RW-1:RW];
    assign rd_rank = i_rd_data[RW-1:0];
    assign is_full = (r_count == CW'(WINDOW));
    assign cnt_new = is_full ? r_count : r_count + CW'(1);
    assign issue   = (r_ptr < r_held) && (r_ptr != CW'(r_s));
    assign scan_end = (r_ptr == r_held) && !r_pv;
    assign rank_a  = rd_rank - RW'(r_full && (rd_rank > r_rold));
    assign rank_b  = rank_a + RW'(rd_val > r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smt_pkg::S_IDLE;
            r_slot  <= '0;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_count <= n_count;
            r_pv    <= n_pv;
        end
        r_t    <= n_t;
        r_med  <= n_med;
        r_s    <= n_s;
        r_pa   <= n_pa;
        r_held <= n_held;
        r_ptr  <= n_ptr;
        r_used <= n_used;
        r_k2   <= n_k2;
        r_rold <= n_rold;
        r_le   <= n_le;
        r_full <= n_full;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smt_pkg::S_IDLE:  if (i_valid) n_state = smt_pkg::S_OLD;
            smt_pkg::S_OLD:   n_state = smt_pkg::S_SCAN;
            smt_pkg::S_SCAN:  if (scan_end) n_state = smt_pkg::S_WRITE;
            smt_pkg::S_WRITE: n_state = smt_pkg::S_DONE;
            smt_pkg::S_DONE:  if (i_res_ready) n_state = smt_pkg::S_IDLE;
            default:          n_state = smt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_t       = r_t;
        n_med     = r_med;
        n_s       = r_s;
        n_pa      = r_pa;
        n_held    = r_held;
        n_ptr     = r_ptr;
        n_used    = r_used;
        n_k2      = r_k2;
        n_rold    = r_rold;
        n_le      = r_le;
        n_full    = r_full;
        n_pv      = 1'b0;
        n_slot    = r_slot;
        n_count   = r_count;
        o_ready   = 1'b0;
        o_res_valid = 1'b0;
        o_mem_cmd = '0;
        o_rd_addr = r_slot;
        o_wr_addr = r_pa;
        o_wr_data = {rd_val, rank_b};
        unique case (r_state)
            smt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_mem_cmd.rd_en = 1'b1;
                    n_t    = i_block_time;
                    n_s    = r_slot;
                    n_full = is_full;
                    n_held = r_count;
                    n_used = cnt_new;
                    n_k2   = RW'(cnt_new >> 1);
                    n_ptr  = '0;
                    n_le   = '0;
                end
            end
            smt_pkg::S_OLD: begin
                n_rold = rd_rank;
            end
            smt_pkg::S_SCAN: begin
                o_rd_addr       = r_ptr[IW-1:0];
                o_mem_cmd.rd_en = issue;
                n_pv            = issue;
                n_pa            = r_ptr[IW-1:0];
                if (r_ptr < r_held) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_pv) begin
                    o_mem_cmd.wr_en = 1'b1;
                    if (rd_val <= r_t) n_le = r_le + RW'(1);
                    if (rank_b == r_k2) n_med = rd_val;
                end
            end
            smt_pkg::S_WRITE: begin
                o_mem_cmd.wr_en = 1'b1;
                o_wr_addr       = r_s;
                o_wr_data       = {r_t, r_le};
                if (r_le == r_k2) n_med = r_t;
                n_slot  = (r_s == IW'(WINDOW - 1)) ? '0 : r_s + IW'(1);
                n_count = r_used;
            end
            smt_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_median = r_med;
    assign o_used   = r_used;

endmodule

// ===== src/sliding_median_of_timestamps_core.sv =====
// Top level: input handshake, rank engine, window store and output register.
// Uses smt_pkg, smt_window_mem and smt_rank_engine.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | i_valid, o_ready, i_block_time       | item in
//  out     | o_valid, i_ready, o_median_time,     | item out
//          | o_entries_used                       |
//
// The next item is accepted only after the current one has made its pass over the
// timestamps held before it (all but the oldest once the window is full), one at a
// time through the store's single read port, and after its result has gone on to
// the output register.
// Reset empties the window; the store itself is not cleared.
// A result waits in the output register while the next item is processed.
module sliding_median_of_timestamps_core #(
    parameter int WINDOW = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [smt_pkg::TIME_W-1:0] i_block_time,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [smt_pkg::TIME_W-1:0] o_median_time,
    output logic [smt_pkg::USED_W-1:0] o_entries_used
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int DW = smt_pkg::TIME_W + RW;

    smt_pkg::t_mem_cmd          mem_cmd;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              wr_addr;
    logic [DW-1:0]              wr_data;
    logic [DW-1:0]              rd_data;
    logic                       res_valid;
    logic                       res_ready;
    logic [smt_pkg::TIME_W-1:0] res_median;
    logic [CW-1:0]              res_used;

    logic                       r_out_valid;
    logic [smt_pkg::TIME_W-1:0] r_out_median;
    logic [smt_pkg::USED_W-1:0] r_out_used;

    smt_window_mem #(
        .DEPTH (WINDOW),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    smt_rank_engine #(
        .WINDOW (WINDOW),
        .IW     (IW),
        .RW     (RW),
        .CW     (CW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_time (i_block_time),
        .o_mem_cmd    (mem_cmd),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_median     (res_median),
        .o_used       (res_used)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out_median <= res_median;
            r_out_used   <= smt_pkg::USED_W'(res_used);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_median_time  = r_out_median;
    assign o_entries_used = r_out_used;

endmodule
